>>> src/vpeb_pkg.sv
// ----------------------------------------------------------------------------
// vpeb_pkg
// Shared types, constants and fixed-point helpers for the particle block.
// ----------------------------------------------------------------------------
`default_nettype none

package vpeb_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 13;

    // Fixed-point constants (Q16.16 unless noted).
    localparam int GRAVITY_Q16     = 13107;
    localparam int RESTITUTION_Q16 = 39322;   // Q0.16
    localparam int SPEED_SOUND_MIN = 16384;
    localparam int SPEED_PAIN_MIN  = 327680;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SCREEN_WIDTH    = 3'd0,
        REG_SCREEN_HEIGHT   = 3'd1,
        REG_PARTICLE_RADIUS = 3'd2,
        REG_RAGDOLL_MODE    = 3'd3,
        REG_SPRITE_KIND     = 3'd4
    } reg_idx_t;

    typedef enum logic [1:0] {
        FN_TICK    = 2'd0,
        FN_PLACE   = 2'd1,
        FN_IMPULSE = 2'd2
    } func_t;

    typedef enum logic [1:0] {
        SND_NONE  = 2'd0,
        SND_PAIN  = 2'd1,
        SND_BOING = 2'd2,
        SND_THUMP = 2'd3
    } sound_t;

    localparam logic [1:0] SPRITE_BALL = 2'd1;
    localparam logic [1:0] SPRITE_WOOD = 2'd2;

    typedef struct packed {
        logic [12:0] screen_width;
        logic [12:0] screen_height;
        logic [9:0]  particle_radius;
        logic        ragdoll_mode;
        logic [1:0]  sprite_kind;
    } cfg_t;

    typedef struct packed {
        logic signed [31:0] cur_x;
        logic signed [31:0] cur_y;
        logic signed [31:0] prev_x;
        logic signed [31:0] prev_y;
    } pstate_t;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic [30:0]        hit_speed;
        logic [1:0]         sound_code;
    } result_t;

    // Clamp a wide signed value to the signed 32-bit range.
    function automatic logic signed [31:0] sat32(input logic signed [34:0] v);
        logic signed [31:0] r;
        if (v > 35'sh0_7FFF_FFFF) begin
            r = 32'sh7FFF_FFFF;
        end else if (v < -35'sh0_8000_0000) begin
            r = 32'sh8000_0000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    // Scale by the restitution, rounding half away from zero. The delta of a
    // step never reaches 2^32 in magnitude, so 32 bits hold it.
    function automatic logic signed [32:0] damp(input logic signed [32:0] d);
        logic [31:0] mag;
        logic [47:0] prod;
        logic [32:0] m;
        logic signed [32:0] r;
        mag  = d[32] ? 32'(-d) : 32'(d);
        prod = 48'(mag) * 48'(RESTITUTION_Q16) + 48'(32768);
        m    = {1'b0, prod[47:16]};
        r    = d[32] ? -$signed(m) : $signed(m);
        return r;
    endfunction

endpackage

`default_nettype wire

>>> src/vpeb_cfg_regs.sv
// ----------------------------------------------------------------------------
// vpeb_cfg_regs
// Configuration register file written over the index/data write channel.
// ----------------------------------------------------------------------------
`default_nettype none

module vpeb_cfg_regs (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [vpeb_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [vpeb_pkg::CFG_DATA_W-1:0] cfg_data,
    output vpeb_pkg::cfg_t                      cfg
);
    import vpeb_pkg::*;

    cfg_t cfg_reg, cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            unique case (cfg_index)
                REG_SCREEN_WIDTH:    cfg_next.screen_width    = cfg_data[12:0];
                REG_SCREEN_HEIGHT:   cfg_next.screen_height   = cfg_data[12:0];
                REG_PARTICLE_RADIUS: cfg_next.particle_radius = cfg_data[9:0];
                REG_RAGDOLL_MODE:    cfg_next.ragdoll_mode    = cfg_data[0];
                REG_SPRITE_KIND:     cfg_next.sprite_kind     = cfg_data[1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.screen_width    <= 13'd1024;
            cfg_reg.screen_height   <= 13'd768;
            cfg_reg.particle_radius <= 10'd32;
            cfg_reg.ragdoll_mode    <= 1'b0;
            cfg_reg.sprite_kind     <= 2'd0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

`default_nettype wire

>>> src/vpeb_step.sv
// ----------------------------------------------------------------------------
// vpeb_step
// One particle update: Verlet step with gravity, wall clamp and damped
// reflection, hit speed and sound selection, or a place/impulse write.
// ----------------------------------------------------------------------------
`default_nettype none

module vpeb_step (
    input  wire logic [1:0]          func,
    input  wire logic signed [31:0]  vec_x,
    input  wire logic signed [31:0]  vec_y,
    input  wire vpeb_pkg::cfg_t      cfg,
    input  wire vpeb_pkg::pstate_t   st,
    output vpeb_pkg::pstate_t        st_next,
    output vpeb_pkg::result_t        res
);
    import vpeb_pkg::*;

    logic signed [31:0] px, py_v, py, px_c, py_c;
    logic signed [32:0] dx, dy, damp_x, damp_y;
    logic signed [31:0] lo, hix, hiy;
    logic signed [13:0] span_x, span_y;
    logic               xhit, yhit;
    logic [32:0]        abs_x, abs_y, speed;
    logic signed [34:0] adj_x, adj_y;
    logic [1:0]         sound;
    pstate_t            tick_st;

    always_comb begin
        // Verlet step, then gravity on y.
        px   = sat32((35'(st.cur_x) <<< 1) - 35'(st.prev_x));
        py_v = sat32((35'(st.cur_y) <<< 1) - 35'(st.prev_y));
        py   = sat32(35'(py_v) - 35'(GRAVITY_Q16));
        dx   = 33'(px) - 33'(st.cur_x);
        dy   = 33'(py) - 33'(st.cur_y);

        lo     = {6'd0, cfg.particle_radius, 16'd0};
        span_x = $signed({1'b0, cfg.screen_width})  - $signed({4'd0, cfg.particle_radius});
        span_y = $signed({1'b0, cfg.screen_height}) - $signed({4'd0, cfg.particle_radius});
        hix    = {{2{span_x[13]}}, span_x, 16'd0};
        hiy    = {{2{span_y[13]}}, span_y, 16'd0};

        xhit = (px < lo) || (px > hix);
        yhit = (py < lo) || (py > hiy);
        px_c = xhit ? ((px < lo) ? lo : hix) : px;
        py_c = yhit ? ((py < lo) ? lo : hiy) : py;

        damp_x = damp(dx);
        damp_y = damp(dy);

        // A hit on one axis negates the other axis' delta, so a corner hit
        // negates both.
        adj_x = yhit ? -35'(damp_x) : 35'(damp_x);
        adj_y = xhit ? -35'(damp_y) : 35'(damp_y);

        tick_st.cur_x = px_c;
        tick_st.cur_y = py_c;
        if (xhit || yhit) begin
            tick_st.prev_x = sat32(35'(px_c) + adj_x);
            tick_st.prev_y = sat32(35'(py_c) + adj_y);
        end else begin
            tick_st.prev_x = st.cur_x;
            tick_st.prev_y = st.cur_y;
        end

        abs_x = dx[32] ? 33'(-dx) : 33'(dx);
        abs_y = dy[32] ? 33'(-dy) : 33'(dy);
        if (yhit) begin
            speed = abs_y;
        end else if (xhit) begin
            speed = abs_x;
        end else begin
            speed = 33'd0;
        end

        sound = SND_NONE;
        if (speed > 33'(SPEED_SOUND_MIN)) begin
            if (cfg.ragdoll_mode) begin
                if (speed > 33'(SPEED_PAIN_MIN)) begin
                    sound = SND_PAIN;
                end
            end else if (cfg.sprite_kind == SPRITE_BALL) begin
                sound = SND_BOING;
            end else if (cfg.sprite_kind == SPRITE_WOOD) begin
                sound = SND_THUMP;
            end
        end

        st_next        = st;
        res.hit_speed  = 31'd0;
        res.sound_code = SND_NONE;
        case (func)
            FN_TICK: begin
                st_next        = tick_st;
                res.hit_speed  = (speed[32:31] != 2'd0) ? 31'h7FFF_FFFF : speed[30:0];
                res.sound_code = sound;
            end
            FN_PLACE: begin
                st_next.cur_x  = vec_x;
                st_next.cur_y  = vec_y;
                st_next.prev_x = vec_x;
                st_next.prev_y = vec_y;
            end
            FN_IMPULSE: begin
                st_next.prev_x = sat32(35'(st.cur_x) - 35'(vec_x));
                st_next.prev_y = sat32(35'(st.cur_y) - 35'(vec_y));
            end
            default: ;
        endcase
        res.pos_x = st_next.cur_x;
        res.pos_y = st_next.cur_y;
    end

endmodule

`default_nettype wire

>>> src/verlet_particle_edge_bounce.sv
// ----------------------------------------------------------------------------
// verlet_particle_edge_bounce
// Single-particle Verlet integrator with damped wall reflection.
// ----------------------------------------------------------------------------
// Takes one beat per clock cycle on the input stream, unless the result
// stream is stalled, and returns exactly one result beat per input beat. An
// accepted beat is held in the input register and moves to the result
// register once that is free or being drained. Each beat passes an input
// register, then one step of combinational update logic that also writes the
// particle state, then the result register; the state feedback through that
// single step is what sets the one-beat-per-cycle rate. Input tuser carries
// the item kind (tick, place, impulse); configuration writes must be made
// while the block is idle.
`default_nettype none

module verlet_particle_edge_bounce (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    // Input stream
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [63:0]  s_tdata,   // vec_x[31:0], vec_y[63:32]
    input  wire logic [1:0]   s_tuser,   // func[1:0]
    // Result stream
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [103:0]      m_tdata,   // pos_x[31:0], pos_y[63:32],
                                         // hit_speed[94:64], sound_code[96:95]
    // Configuration write channel
    input  wire logic         cfg_valid,
    output logic              cfg_ready,
    input  wire logic [vpeb_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [vpeb_pkg::CFG_DATA_W-1:0] cfg_data
);
    import vpeb_pkg::*;

    cfg_t    cfg;
    pstate_t st_reg, st_next;
    result_t res_reg, res_next;

    logic               in_vld_reg, in_vld_next;
    logic [1:0]         func_reg;
    logic signed [31:0] vx_reg, vy_reg;
    logic               out_vld_reg, out_vld_next;
    logic               s_acc, fire;

    vpeb_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    vpeb_step u_step (
        .func    (func_reg),
        .vec_x   (vx_reg),
        .vec_y   (vy_reg),
        .cfg     (cfg),
        .st      (st_reg),
        .st_next (st_next),
        .res     (res_next)
    );

    // The input register advances whenever the result register is free or
    // being drained in the same cycle.
    assign fire     = in_vld_reg && (!out_vld_reg || m_tready);
    assign s_tready = !in_vld_reg || fire;
    assign s_acc    = s_tvalid && s_tready;

    assign in_vld_next  = s_acc ? 1'b1 : (fire ? 1'b0 : in_vld_reg);
    assign out_vld_next = fire ? 1'b1 : (m_tready ? 1'b0 : out_vld_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
            st_reg      <= '0;
        end else begin
            in_vld_reg  <= in_vld_next;
            out_vld_reg <= out_vld_next;
            if (fire) begin
                st_reg <= st_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_acc) begin
            func_reg <= s_tuser;
            vx_reg   <= s_tdata[31:0];
            vy_reg   <= s_tdata[63:32];
        end
        if (fire) begin
            res_reg <= res_next;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {7'd0, res_reg.sound_code, res_reg.hit_speed,
                       res_reg.pos_y, res_reg.pos_x};

    assert property (@(posedge aclk) !aresetn |=> !m_tvalid && !in_vld_reg)
        else $error("pipeline not empty after reset");

    assert property (@(posedge aclk) disable iff (!aresetn)
        fire |=> m_tvalid)
        else $error("processed beat did not reach the result register");

    assert property (@(posedge aclk) disable iff (!aresetn)
        in_vld_reg && !fire |-> !s_tready)
        else $error("input accepted while the input register is blocked");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && res_reg.hit_speed == 31'd0 |-> res_reg.sound_code == SND_NONE)
        else $error("sound reported without a wall hit");

endmodule

`default_nettype wire
